// ----- design/echo_escape_decoder_top_macros.svh -----
// Assertion macros shared by the echo escape decoder modules.
// Taken in by `include; define NO_ASSERTIONS to compile them out.
`ifndef ECHO_ESCAPE_DECODER_TOP_MACROS_SVH
`define ECHO_ESCAPE_DECODER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define EED_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("eed: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define EED_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("eed: next-cycle check failed");

`else

`define EED_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define EED_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- design/eed_pkg.sv -----
// Types, codes and character helpers for the echo escape decoder.
// No dependencies; used by eed_decode, eed_outbuf and the top level.
package eed_pkg;

    typedef enum logic [1:0] {
        OP_CHAR = 2'd0,
        OP_SEP  = 2'd1,
        OP_END  = 2'd2,
        OP_NONE = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_BSLASH = 3'd1,
        MODE_HEX    = 3'd2,
        MODE_OCT    = 3'd3,
        MODE_STOP   = 3'd4
    } t_mode;

    typedef enum logic {
        REG_ESCAPES_ENABLED = 1'b0,
        REG_OMIT_NEWLINE    = 1'b1
    } t_reg_index;

    localparam int unsigned MAX_RESULTS = 3;
    localparam int unsigned CNT_W       = 2;
    localparam int unsigned VALUE_W     = 9;

    localparam logic [7:0] ESC_BYTE     = 8'd27;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_LOWER_X   = 8'h78;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_LOWER_C   = 8'h63;

    localparam logic [VALUE_W-1:0] HEX_BASE = 9'd16;
    localparam logic [VALUE_W-1:0] OCT_BASE = 9'd8;
    localparam logic [CNT_W-1:0]   HEX_DIGITS = 2'd2;
    localparam logic [CNT_W-1:0]   OCT_DIGITS = 2'd3;

    // Decoded words for one item, first word in bytes[0].
    typedef struct packed {
        logic [CNT_W-1:0]             count;
        logic [MAX_RESULTS-1:0][7:0]  bytes;
    } t_result;

    // {valid, value} of an ASCII hex digit.
    function automatic logic [4:0] hex_digit(input logic [7:0] ch);
        logic [4:0] r;
        r = 5'd0;
        if (ch >= "0" && ch <= "9") begin
            r = {1'b1, 4'(ch - "0")};
        end else if (ch >= "a" && ch <= "f") begin
            r = {1'b1, 4'(ch - "a" + 8'd10)};
        end else if (ch >= "A" && ch <= "F") begin
            r = {1'b1, 4'(ch - "A" + 8'd10)};
        end
        return r;
    endfunction

    // {valid, code} of a single-letter control escape.
    function automatic logic [8:0] letter_escape(input logic [7:0] ch);
        logic [8:0] r;
        case (ch)
            "a":          r = {1'b1, 8'd7};
            "b":          r = {1'b1, 8'd8};
            "e":          r = {1'b1, ESC_BYTE};
            "f":          r = {1'b1, 8'd12};
            "n":          r = {1'b1, 8'd10};
            "r":          r = {1'b1, 8'd13};
            "t":          r = {1'b1, 8'd9};
            "v":          r = {1'b1, 8'd11};
            CH_BACKSLASH: r = {1'b1, CH_BACKSLASH};
            default:      r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- design/eed_if.sv -----
// Valid/ready channel interfaces of the echo escape decoder.
// Depends on nothing but the payload widths fixed here.
interface eed_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] char_in;

    modport source (output valid, output opcode, output char_in, input ready);
    modport sink   (input valid, input opcode, input char_in, output ready);
endinterface

interface eed_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

interface eed_cfg_if;
    logic valid;
    logic ready;
    logic index;
    logic data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/eed_decode.sv -----
// Escape state registers and the one-pass decode of a stored word.
// Depends on eed_pkg and the assertion macro header.
`include "echo_escape_decoder_top_macros.svh"

module eed_decode (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  eed_pkg::t_opcode   i_op,
    input  logic [7:0]         i_char,
    input  logic               i_esc_en,
    input  logic               i_omit_nl,
    output eed_pkg::t_result   o_res
);

    eed_pkg::t_mode                      r_mode, n_mode;
    logic [eed_pkg::CNT_W-1:0]           r_count, n_count;
    logic [eed_pkg::VALUE_W-1:0]         r_value, n_value;

    always_comb begin
        logic [1:0]                          k;
        logic [eed_pkg::MAX_RESULTS-1:0][7:0] b;
        logic [4:0]                          hd;
        logic [8:0]                          le;
        logic                                dig;
        logic                                do_flush;
        logic [eed_pkg::CNT_W-1:0]           lim;

        k       = 2'd0;
        b       = '0;
        lim     = eed_pkg::HEX_DIGITS;
        n_mode  = r_mode;
        n_count = r_count;
        n_value = r_value;
        hd      = eed_pkg::hex_digit(i_char);
        le      = eed_pkg::letter_escape(i_char);
        dig     = hd[4] && (r_mode == eed_pkg::MODE_HEX ||
                            (r_mode == eed_pkg::MODE_OCT && !hd[3]));

        do_flush = (i_op == eed_pkg::OP_CHAR &&
                    (r_mode == eed_pkg::MODE_HEX || r_mode == eed_pkg::MODE_OCT) && !dig) ||
                   ((i_op == eed_pkg::OP_SEP || i_op == eed_pkg::OP_END) &&
                    r_mode != eed_pkg::MODE_STOP);

        // close any open escape before the byte, space or newline
        if (do_flush) begin
            case (r_mode)
                eed_pkg::MODE_BSLASH: begin
                    b[k] = eed_pkg::CH_BACKSLASH;
                    k    = k + 2'd1;
                end
                eed_pkg::MODE_HEX, eed_pkg::MODE_OCT: begin
                    if (r_count == '0) begin
                        b[k] = eed_pkg::CH_BACKSLASH;
                        k    = k + 2'd1;
                        b[k] = (r_mode == eed_pkg::MODE_HEX) ? eed_pkg::CH_LOWER_X
                                                             : eed_pkg::CH_ZERO;
                        k    = k + 2'd1;
                    end else if (r_value[7:0] != 8'd0) begin
                        b[k] = r_value[7:0];
                        k    = k + 2'd1;
                    end
                end
                default: ;
            endcase
            n_mode  = eed_pkg::MODE_NORMAL;
            n_count = '0;
            n_value = '0;
        end

        case (i_op)
            eed_pkg::OP_CHAR: begin
                case (n_mode)
                    eed_pkg::MODE_STOP: ;
                    eed_pkg::MODE_BSLASH: begin
                        n_mode  = eed_pkg::MODE_NORMAL;
                        n_count = '0;
                        n_value = '0;
                        if (le[8]) begin
                            b[k] = le[7:0];
                            k    = k + 2'd1;
                        end else if (i_char == eed_pkg::CH_LOWER_X) begin
                            n_mode = eed_pkg::MODE_HEX;
                        end else if (i_char == eed_pkg::CH_ZERO) begin
                            n_mode = eed_pkg::MODE_OCT;
                        end else if (i_char == eed_pkg::CH_LOWER_C) begin
                            n_mode = eed_pkg::MODE_STOP;
                        end else begin
                            b[k] = eed_pkg::CH_BACKSLASH;
                            k    = k + 2'd1;
                            b[k] = i_char;
                            k    = k + 2'd1;
                        end
                    end
                    eed_pkg::MODE_HEX, eed_pkg::MODE_OCT: begin
                        // only digits reach here; others were flushed above
                        if (n_mode == eed_pkg::MODE_HEX) begin
                            n_value = 9'(r_value * eed_pkg::HEX_BASE) + 9'(hd[3:0]);
                            lim     = eed_pkg::HEX_DIGITS;
                        end else begin
                            n_value = 9'(r_value * eed_pkg::OCT_BASE) + 9'(hd[2:0]);
                            lim     = eed_pkg::OCT_DIGITS;
                        end
                        n_count = r_count + 2'd1;
                        if (n_count >= lim) begin
                            if (n_value[7:0] != 8'd0) begin
                                b[k] = n_value[7:0];
                                k    = k + 2'd1;
                            end
                            n_mode  = eed_pkg::MODE_NORMAL;
                            n_count = '0;
                            n_value = '0;
                        end
                    end
                    default: begin
                        n_mode = eed_pkg::MODE_NORMAL;
                        if (i_esc_en && i_char == eed_pkg::CH_BACKSLASH) begin
                            n_mode = eed_pkg::MODE_BSLASH;
                        end else begin
                            b[k] = i_char;
                            k    = k + 2'd1;
                        end
                    end
                endcase
            end
            eed_pkg::OP_SEP: begin
                if (r_mode != eed_pkg::MODE_STOP) begin
                    b[k] = eed_pkg::CH_SPACE;
                    k    = k + 2'd1;
                end
            end
            eed_pkg::OP_END: begin
                if (r_mode != eed_pkg::MODE_STOP && !i_omit_nl) begin
                    b[k] = eed_pkg::CH_NEWLINE;
                    k    = k + 2'd1;
                end
                n_mode  = eed_pkg::MODE_NORMAL;
                n_count = '0;
                n_value = '0;
            end
            default: ;
        endcase

        o_res.count = k;
        o_res.bytes = b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= eed_pkg::MODE_NORMAL;
            r_count <= '0;
            r_value <= '0;
        end else if (i_advance) begin
            r_mode  <= n_mode;
            r_count <= n_count;
            r_value <= n_value;
        end
    end

    `EED_ASSERT_IMPL(a_stop_silent, i_clk, i_rst_n, r_mode == eed_pkg::MODE_STOP, o_res.count == '0)
    `EED_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, i_advance && i_op == eed_pkg::OP_END, r_mode == eed_pkg::MODE_NORMAL && r_count == '0 && r_value == '0)

endmodule

// ----- design/eed_outbuf.sv -----
// Result register: holds up to three decoded words and sends them in order.
// Depends on eed_pkg, eed_out_if and the assertion macro header.
`include "echo_escape_decoder_top_macros.svh"

module eed_outbuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  eed_pkg::t_result  i_res,
    output logic              o_space,
    eed_out_if.source         o_out
);

    logic [eed_pkg::CNT_W-1:0]               r_cnt, n_cnt;
    logic [eed_pkg::MAX_RESULTS-1:0][7:0]    r_byte, n_byte;
    logic                                    take;

    assign take          = o_out.valid && o_out.ready;
    assign o_space       = (r_cnt == '0) || (r_cnt == 2'd1 && o_out.ready);
    assign o_out.valid   = (r_cnt != '0);
    assign o_out.out_byte    = r_byte[0];
    assign o_out.last_of_run = (r_cnt == 2'd1);

    always_comb begin
        n_cnt  = r_cnt;
        n_byte = r_byte;
        if (i_load) begin
            n_cnt  = i_res.count;
            n_byte = i_res.bytes;
        end else if (take) begin
            // advance to the next word of the run
            n_cnt  = r_cnt - 2'd1;
            n_byte = {8'd0, r_byte[eed_pkg::MAX_RESULTS-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    `EED_ASSERT_IMPL(a_load_has_space, i_clk, i_rst_n, i_load, o_space && i_res.count != '0)
    `EED_ASSERT_NEXT(a_run_continues, i_clk, i_rst_n, take && r_cnt > 2'd1, o_out.valid)

endmodule

// ----- design/echo_escape_decoder_top.sv -----
// Echo escape decoder, top level: input register, decode, result register.
// Depends on eed_pkg, the channel interfaces, eed_decode and eed_outbuf.
//
// Takes one word per clock (opcode plus byte) unless held by back-pressure,
// and returns the decoded output bytes in order, the last byte caused by each
// word flagged with last_of_run. A word that yields at most one byte passes
// at one word per cycle while the output is ready; one that yields more (up
// to three) holds the result register until the output channel, one byte per
// cycle when ready, has taken them. Words that yield nothing (a backslash,
// escape digits, anything after \c) leave no gap. Write escapes_enabled and
// omit_newline only while the block is idle.

module echo_escape_decoder_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    eed_in_if.sink    i_in,
    eed_cfg_if.sink   i_cfg,
    eed_out_if.source o_out
);

    logic                r_in_valid;
    eed_pkg::t_opcode    r_op;
    logic [7:0]          r_char;
    logic                r_esc_en;
    logic                r_omit_nl;
    logic                space;
    logic                advance;
    eed_pkg::t_result    res;

    assign advance    = r_in_valid && space;
    assign i_in.ready = !r_in_valid || space;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_op   <= eed_pkg::t_opcode'(i_in.opcode);
            r_char <= i_in.char_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc_en  <= 1'b0;
            r_omit_nl <= 1'b0;
        end else if (i_cfg.valid) begin
            case (eed_pkg::t_reg_index'(i_cfg.index))
                eed_pkg::REG_ESCAPES_ENABLED: r_esc_en  <= i_cfg.data;
                eed_pkg::REG_OMIT_NEWLINE:    r_omit_nl <= i_cfg.data;
                default: ;
            endcase
        end
    end

    eed_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_op      (r_op),
        .i_char    (r_char),
        .i_esc_en  (r_esc_en),
        .i_omit_nl (r_omit_nl),
        .o_res     (res)
    );

    eed_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && res.count != '0),
        .i_res   (res),
        .o_space (space),
        .o_out   (o_out)
    );

endmodule
